>>> hdl/segment_pair_intersection_assert.svh
// ----------------------------------------------------------------------------
// Segment pair intersection assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_PAIR_INTERSECTION_ASSERT_SVH
`define SEGMENT_PAIR_INTERSECTION_ASSERT_SVH

// An implication that is checked on every rising edge outside reset.
`define SPI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A result strobe must trace back to an accepted transfer, looked up with $past at the given depth.
`define SPI_ASSERT_PAST(label, clk, rst_n, ante, cause, depth, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |-> $past(cause, depth)) \
        else $error(msg);

`endif

>>> hdl/spi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment pair intersection package
// Widths, shared types and helper functions.
// ----------------------------------------------------------------------------
package spi_pkg;

    localparam int CW      = 16;         // coordinate width
    localparam int DW      = CW + 1;     // coordinate difference width
    localparam int MW      = 2 * CW + 2; // line constant and determinant width
    localparam int NW      = 3 * CW + 4; // Cramer numerator width
    localparam int QW      = CW + 1;     // quotient magnitude bits
    localparam int RW      = NW + 1;     // divider remainder width
    localparam int LATENCY = QW + 9;     // edges from transfer to result strobe

    typedef logic signed [CW-1:0] t_coord;

    typedef struct packed {
        logic              hit;
        logic              col;
        logic signed [NW-1:0] num_x;
        logic signed [NW-1:0] num_y;
        logic [MW-1:0]     den;
        t_coord            lx;
        t_coord            ly;
        t_coord            rx;
        t_coord            ry;
    } t_div_in;

    function automatic t_coord cmin(input t_coord p, input t_coord q);
        return (p < q) ? p : q;
    endfunction

    function automatic t_coord cmax(input t_coord p, input t_coord q);
        return (p > q) ? p : q;
    endfunction

    function automatic logic lex_less(input t_coord px, input t_coord py,
                                      input t_coord qx, input t_coord qy);
        return (px < qx) || ((px == qx) && (py < qy));
    endfunction

endpackage

>>> hdl/spi_geom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment pair geometry pipeline
// Seven stages: line equations, determinant, Cramer numerators and box tests.
// ----------------------------------------------------------------------------
module spi_geom (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  spi_pkg::t_coord   i_a_x,
    input  spi_pkg::t_coord   i_a_y,
    input  spi_pkg::t_coord   i_b_x,
    input  spi_pkg::t_coord   i_b_y,
    input  spi_pkg::t_coord   i_c_x,
    input  spi_pkg::t_coord   i_c_y,
    input  spi_pkg::t_coord   i_d_x,
    input  spi_pkg::t_coord   i_d_y,
    output logic              o_valid,
    output spi_pkg::t_div_in  o_data
);

    localparam int DW = spi_pkg::DW;
    localparam int MW = spi_pkg::MW;
    localparam int NW = spi_pkg::NW;

    typedef struct packed {
        spi_pkg::t_coord ax, ay, bx, by, cx, cy, dx, dy;
        spi_pkg::t_coord lx, ly, rx, ry;
        logic            box;
    } t_carry;

    logic [7:1] r_v;

    // Stage 1
    t_carry                r1_c;
    logic signed [DW-1:0]  r1_ma, r1_mb, r1_na, r1_nb, r1_ex, r1_ey;
    // Stage 2
    t_carry                r2_c;
    logic signed [DW-1:0]  r2_ma, r2_mb, r2_na, r2_nb;
    logic signed [MW-1:0]  r2_pa, r2_pb, r2_pc, r2_pd, r2_pe, r2_pf;
    logic signed [MW-1:0]  r2_k1, r2_k2, r2_k3, r2_k4;
    // Stage 3
    t_carry                r3_c;
    logic signed [DW-1:0]  r3_ma, r3_mb, r3_na, r3_nb;
    logic signed [MW-1:0]  r3_mc, r3_nc, r3_zn;
    logic                  r3_on;
    // Stage 4
    t_carry                r4_c;
    logic signed [NW-1:0]  r4_q1, r4_q2, r4_q3, r4_q4;
    logic signed [MW-1:0]  r4_zn;
    logic                  r4_on;
    // Stage 5
    t_carry                r5_c;
    logic signed [NW-1:0]  r5_nx, r5_ny;
    logic signed [MW-1:0]  r5_den;
    logic                  r5_on, r5_par;
    // Stage 6
    t_carry                r6_c;
    logic signed [NW-1:0]  r6_nx, r6_ny;
    logic signed [MW-1:0]  r6_den;
    logic signed [NW-1:0]  r6_lo [0:3];
    logic signed [NW-1:0]  r6_hi [0:3];
    logic                  r6_on, r6_par;
    // Stage 7
    spi_pkg::t_div_in      r7_d;

    // Stage 1 logic: box overlap and the lexicographic overlap range.
    t_carry          n1_c;
    spi_pkg::t_coord s_ax, s_ay, s_bx, s_by, s_cx, s_cy, s_dx, s_dy;
    logic            swap_ab, swap_cd;

    always_comb begin
        swap_ab = spi_pkg::lex_less(i_b_x, i_b_y, i_a_x, i_a_y);
        swap_cd = spi_pkg::lex_less(i_d_x, i_d_y, i_c_x, i_c_y);
        s_ax = swap_ab ? i_b_x : i_a_x;
        s_ay = swap_ab ? i_b_y : i_a_y;
        s_bx = swap_ab ? i_a_x : i_b_x;
        s_by = swap_ab ? i_a_y : i_b_y;
        s_cx = swap_cd ? i_d_x : i_c_x;
        s_cy = swap_cd ? i_d_y : i_c_y;
        s_dx = swap_cd ? i_c_x : i_d_x;
        s_dy = swap_cd ? i_c_y : i_d_y;
        n1_c.ax = i_a_x;
        n1_c.ay = i_a_y;
        n1_c.bx = i_b_x;
        n1_c.by = i_b_y;
        n1_c.cx = i_c_x;
        n1_c.cy = i_c_y;
        n1_c.dx = i_d_x;
        n1_c.dy = i_d_y;
        if (spi_pkg::lex_less(s_ax, s_ay, s_cx, s_cy)) begin
            n1_c.lx = s_cx;
            n1_c.ly = s_cy;
        end else begin
            n1_c.lx = s_ax;
            n1_c.ly = s_ay;
        end
        if (spi_pkg::lex_less(s_dx, s_dy, s_bx, s_by)) begin
            n1_c.rx = s_dx;
            n1_c.ry = s_dy;
        end else begin
            n1_c.rx = s_bx;
            n1_c.ry = s_by;
        end
        n1_c.box =
            (spi_pkg::cmax(spi_pkg::cmin(i_a_x, i_b_x), spi_pkg::cmin(i_c_x, i_d_x)) <=
             spi_pkg::cmin(spi_pkg::cmax(i_a_x, i_b_x), spi_pkg::cmax(i_c_x, i_d_x))) &&
            (spi_pkg::cmax(spi_pkg::cmin(i_a_y, i_b_y), spi_pkg::cmin(i_c_y, i_d_y)) <=
             spi_pkg::cmin(spi_pkg::cmax(i_a_y, i_b_y), spi_pkg::cmax(i_c_y, i_d_y)));
    end

    // Stage 7 logic: the crossing must lie inside both boxes.
    logic in_all;

    always_comb begin
        in_all = 1'b1;
        for (int k = 0; k < 4; k++) begin
            if (k < 2) begin
                if (!((r6_lo[k] <= r6_nx) && (r6_nx <= r6_hi[k]))) begin
                    in_all = 1'b0;
                end
            end else begin
                if (!((r6_lo[k] <= r6_ny) && (r6_ny <= r6_hi[k]))) begin
                    in_all = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[6:1], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        // Stage 1: line coefficients and offsets of C from A.
        r1_c  <= n1_c;
        r1_ma <= DW'(i_a_y) - DW'(i_b_y);
        r1_mb <= DW'(i_b_x) - DW'(i_a_x);
        r1_na <= DW'(i_c_y) - DW'(i_d_y);
        r1_nb <= DW'(i_d_x) - DW'(i_c_x);
        r1_ex <= DW'(i_c_x) - DW'(i_a_x);
        r1_ey <= DW'(i_c_y) - DW'(i_a_y);

        // Stage 2: first products.
        r2_c  <= r1_c;
        r2_ma <= r1_ma;
        r2_mb <= r1_mb;
        r2_na <= r1_na;
        r2_nb <= r1_nb;
        r2_pa <= MW'(r1_ma) * MW'(r1_c.ax);
        r2_pb <= MW'(r1_mb) * MW'(r1_c.ay);
        r2_pc <= MW'(r1_na) * MW'(r1_c.cx);
        r2_pd <= MW'(r1_nb) * MW'(r1_c.cy);
        r2_pe <= MW'(r1_ma) * MW'(r1_nb);
        r2_pf <= MW'(r1_mb) * MW'(r1_na);
        r2_k1 <= MW'(r1_ma) * MW'(r1_ex);
        r2_k2 <= MW'(r1_mb) * MW'(r1_ey);
        r2_k3 <= MW'(r1_na) * MW'(r1_ex);
        r2_k4 <= MW'(r1_nb) * MW'(r1_ey);

        // Stage 3: line constants, determinant and the on-line tests.
        r3_c  <= r2_c;
        r3_ma <= r2_ma;
        r3_mb <= r2_mb;
        r3_na <= r2_na;
        r3_nb <= r2_nb;
        r3_mc <= -(r2_pa + r2_pb);
        r3_nc <= -(r2_pc + r2_pd);
        r3_zn <= r2_pe - r2_pf;
        r3_on <= ((r2_k1 + r2_k2) == '0) && ((r2_k3 + r2_k4) == '0);

        // Stage 4: numerator products.
        r4_c  <= r3_c;
        r4_zn <= r3_zn;
        r4_on <= r3_on;
        r4_q1 <= NW'(r3_mb) * NW'(r3_nc);
        r4_q2 <= NW'(r3_mc) * NW'(r3_nb);
        r4_q3 <= NW'(r3_mc) * NW'(r3_na);
        r4_q4 <= NW'(r3_ma) * NW'(r3_nc);

        // Stage 5: numerators, with the sign moved so the denominator is positive.
        r5_c   <= r4_c;
        r5_on  <= r4_on;
        r5_par <= (r4_zn == '0);
        if (r4_zn < 0) begin
            r5_nx  <= r4_q2 - r4_q1;
            r5_ny  <= r4_q4 - r4_q3;
            r5_den <= -r4_zn;
        end else begin
            r5_nx  <= r4_q1 - r4_q2;
            r5_ny  <= r4_q3 - r4_q4;
            r5_den <= r4_zn;
        end

        // Stage 6: box edges scaled by the denominator.
        r6_c   <= r5_c;
        r6_on  <= r5_on;
        r6_par <= r5_par;
        r6_nx  <= r5_nx;
        r6_ny  <= r5_ny;
        r6_den <= r5_den;
        r6_lo[0] <= NW'(spi_pkg::cmin(r5_c.ax, r5_c.bx)) * NW'(r5_den);
        r6_hi[0] <= NW'(spi_pkg::cmax(r5_c.ax, r5_c.bx)) * NW'(r5_den);
        r6_lo[1] <= NW'(spi_pkg::cmin(r5_c.cx, r5_c.dx)) * NW'(r5_den);
        r6_hi[1] <= NW'(spi_pkg::cmax(r5_c.cx, r5_c.dx)) * NW'(r5_den);
        r6_lo[2] <= NW'(spi_pkg::cmin(r5_c.ay, r5_c.by)) * NW'(r5_den);
        r6_hi[2] <= NW'(spi_pkg::cmax(r5_c.ay, r5_c.by)) * NW'(r5_den);
        r6_lo[3] <= NW'(spi_pkg::cmin(r5_c.cy, r5_c.dy)) * NW'(r5_den);
        r6_hi[3] <= NW'(spi_pkg::cmax(r5_c.cy, r5_c.dy)) * NW'(r5_den);

        // Stage 7: final decision.
        r7_d.col   <= r6_c.box && r6_par && r6_on;
        r7_d.hit   <= r6_c.box && (r6_par ? r6_on : in_all);
        r7_d.num_x <= r6_nx;
        r7_d.num_y <= r6_ny;
        r7_d.den   <= MW'(unsigned'(r6_den));
        r7_d.lx    <= r6_c.lx;
        r7_d.ly    <= r6_c.ly;
        r7_d.rx    <= r6_c.rx;
        r7_d.ry    <= r6_c.ry;
    end

    assign o_valid = r_v[7];
    assign o_data  = r7_d;

endmodule

>>> hdl/spi_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment pair crossing divider
// Pipelined restoring divider, one quotient bit per stage, x and y side by side.
// ----------------------------------------------------------------------------
module spi_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  spi_pkg::t_div_in  i_data,
    output logic              o_valid,
    output logic              o_hit,
    output logic              o_collinear,
    output spi_pkg::t_coord   o_left_x,
    output spi_pkg::t_coord   o_left_y,
    output spi_pkg::t_coord   o_right_x,
    output spi_pkg::t_coord   o_right_y
);

    localparam int CW = spi_pkg::CW;
    localparam int MW = spi_pkg::MW;
    localparam int QW = spi_pkg::QW;
    localparam int RW = spi_pkg::RW;

    typedef struct packed {
        logic            hit;
        logic            col;
        logic            neg_x;
        logic            neg_y;
        logic [MW-1:0]   den;
        spi_pkg::t_coord lx, ly, rx, ry;
    } t_side;

    logic [QW:0]    r_v;
    t_side          r_side [0:QW];
    logic [RW-1:0]  r_rem_x [0:QW];
    logic [RW-1:0]  r_rem_y [0:QW];
    logic [QW-1:0]  r_q_x [0:QW];
    logic [QW-1:0]  r_q_y [0:QW];

    logic [RW-1:0]  n_rem_x [1:QW];
    logic [RW-1:0]  n_rem_y [1:QW];
    logic [QW-1:0]  n_q_x [1:QW];
    logic [QW-1:0]  n_q_y [1:QW];
    logic [RW-1:0]  dsh [0:QW-1];

    logic                  r_out_v;
    logic                  r_hit, r_col;
    spi_pkg::t_coord       r_lx, r_ly, r_rx, r_ry;

    // Stage s decides quotient bit QW-1-s.
    always_comb begin
        for (int s = 0; s < QW; s++) begin
            dsh[s] = RW'(r_side[s].den) << (QW - 1 - s);
            if (r_rem_x[s] >= dsh[s]) begin
                n_rem_x[s+1] = r_rem_x[s] - dsh[s];
                n_q_x[s+1]   = {r_q_x[s][QW-2:0], 1'b1};
            end else begin
                n_rem_x[s+1] = r_rem_x[s];
                n_q_x[s+1]   = {r_q_x[s][QW-2:0], 1'b0};
            end
            if (r_rem_y[s] >= dsh[s]) begin
                n_rem_y[s+1] = r_rem_y[s] - dsh[s];
                n_q_y[s+1]   = {r_q_y[s][QW-2:0], 1'b1};
            end else begin
                n_rem_y[s+1] = r_rem_y[s];
                n_q_y[s+1]   = {r_q_y[s][QW-2:0], 1'b0};
            end
        end
    end

    logic [QW-1:0] qx_signed, qy_signed;

    always_comb begin
        qx_signed = r_side[QW].neg_x ? -r_q_x[QW] : r_q_x[QW];
        qy_signed = r_side[QW].neg_y ? -r_q_y[QW] : r_q_y[QW];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            r_out_v <= 1'b0;
        end else begin
            r_v     <= {r_v[QW-1:0], i_valid};
            r_out_v <= r_v[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        // Load: magnitudes of the numerators.
        r_side[0].hit   <= i_data.hit;
        r_side[0].col   <= i_data.col;
        r_side[0].neg_x <= i_data.num_x[spi_pkg::NW-1];
        r_side[0].neg_y <= i_data.num_y[spi_pkg::NW-1];
        r_side[0].den   <= i_data.den;
        r_side[0].lx    <= i_data.lx;
        r_side[0].ly    <= i_data.ly;
        r_side[0].rx    <= i_data.rx;
        r_side[0].ry    <= i_data.ry;
        r_rem_x[0] <= i_data.num_x[spi_pkg::NW-1] ? RW'(-i_data.num_x) : RW'(i_data.num_x);
        r_rem_y[0] <= i_data.num_y[spi_pkg::NW-1] ? RW'(-i_data.num_y) : RW'(i_data.num_y);
        r_q_x[0]   <= '0;
        r_q_y[0]   <= '0;

        for (int s = 1; s <= QW; s++) begin
            r_side[s]  <= r_side[s-1];
            r_rem_x[s] <= n_rem_x[s];
            r_rem_y[s] <= n_rem_y[s];
            r_q_x[s]   <= n_q_x[s];
            r_q_y[s]   <= n_q_y[s];
        end

        // Output: crossing point, overlap range or zeros on a miss.
        r_hit <= r_side[QW].hit;
        r_col <= r_side[QW].col;
        if (r_side[QW].col) begin
            r_lx <= r_side[QW].lx;
            r_ly <= r_side[QW].ly;
            r_rx <= r_side[QW].rx;
            r_ry <= r_side[QW].ry;
        end else if (r_side[QW].hit) begin
            r_lx <= qx_signed[CW-1:0];
            r_ly <= qy_signed[CW-1:0];
            r_rx <= qx_signed[CW-1:0];
            r_ry <= qy_signed[CW-1:0];
        end else begin
            r_lx <= '0;
            r_ly <= '0;
            r_rx <= '0;
            r_ry <= '0;
        end
    end

    assign o_valid     = r_out_v;
    assign o_hit       = r_hit;
    assign o_collinear = r_col;
    assign o_left_x    = r_lx;
    assign o_left_y    = r_ly;
    assign o_right_x   = r_rx;
    assign o_right_y   = r_ry;

endmodule

>>> hdl/segment_pair_intersection.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment pair intersection
// Exact intersection test of two Q8.8 segments with crossing point or overlap.
// ----------------------------------------------------------------------------
// A pair of segments AB and CD is taken on every clock edge at which start is
// high; busy is never raised, so one transfer per cycle is sustained. Each
// transfer produces exactly one result, shown for a single cycle with o_valid
// high, after nine geometry and bookkeeping stages plus one divider stage per
// quotient bit (17 bits at the 16-bit coordinate width). The receiver cannot
// stall the block and must take every result in the cycle it appears. Results
// leave in transfer order. Crossing points are the exact Cramer's-rule
// quotients rounded toward zero; collinear overlaps give the lexicographic
// range max(A, C) to min(B, D); a miss gives all-zero points.
// ----------------------------------------------------------------------------
module segment_pair_intersection (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  spi_pkg::t_coord   i_a_x,
    input  spi_pkg::t_coord   i_a_y,
    input  spi_pkg::t_coord   i_b_x,
    input  spi_pkg::t_coord   i_b_y,
    input  spi_pkg::t_coord   i_c_x,
    input  spi_pkg::t_coord   i_c_y,
    input  spi_pkg::t_coord   i_d_x,
    input  spi_pkg::t_coord   i_d_y,
    output logic              o_valid,
    output logic              o_hit,
    output logic              o_collinear,
    output spi_pkg::t_coord   o_left_x,
    output spi_pkg::t_coord   o_left_y,
    output spi_pkg::t_coord   o_right_x,
    output spi_pkg::t_coord   o_right_y
);

    logic             geom_valid;
    spi_pkg::t_div_in geom_data;

    // The pipeline never holds back, so every start is a transfer.
    assign busy = 1'b0;

    // Line equations, determinant, numerators and the box tests.
    spi_geom u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_a_x   (i_a_x),
        .i_a_y   (i_a_y),
        .i_b_x   (i_b_x),
        .i_b_y   (i_b_y),
        .i_c_x   (i_c_x),
        .i_c_y   (i_c_y),
        .i_d_x   (i_d_x),
        .i_d_y   (i_d_y),
        .o_valid (geom_valid),
        .o_data  (geom_data)
    );

    // Exact division of both numerators and selection of the result points.
    spi_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (geom_valid),
        .i_data      (geom_data),
        .o_valid     (o_valid),
        .o_hit       (o_hit),
        .o_collinear (o_collinear),
        .o_left_x    (o_left_x),
        .o_left_y    (o_left_y),
        .o_right_x   (o_right_x),
        .o_right_y   (o_right_y)
    );

endmodule

>>> hdl/spi_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment pair intersection checker
// Port-level assertions on the results, bound to the top level.
// ----------------------------------------------------------------------------
`include "segment_pair_intersection_assert.svh"

module spi_chk (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input spi_pkg::t_coord   o_left_x,
    input spi_pkg::t_coord   o_left_y,
    input spi_pkg::t_coord   o_right_x,
    input spi_pkg::t_coord   o_right_y,
    input logic              o_valid,
    input logic              o_hit,
    input logic              o_collinear
);

    logic xfer;
    logic pts_zero;
    logic pts_same;

    assign xfer     = start && !busy;
    assign pts_zero = (o_left_x == '0) && (o_left_y == '0) &&
                      (o_right_x == '0) && (o_right_y == '0);
    assign pts_same = (o_left_x == o_right_x) && (o_left_y == o_right_y);

    `SPI_ASSERT_IMP(a_col_hit, i_clk, i_rst_n, o_valid && o_collinear, o_hit, "collinear without hit")

    `SPI_ASSERT_IMP(a_miss_zero, i_clk, i_rst_n, o_valid && !o_hit, pts_zero, "miss with points")

    `SPI_ASSERT_IMP(a_cross_point, i_clk, i_rst_n, o_valid && o_hit && !o_collinear, pts_same, "range")

    `SPI_ASSERT_PAST(a_latency, i_clk, i_rst_n, o_valid, xfer, spi_pkg::LATENCY, "no transfer")

endmodule

bind segment_pair_intersection spi_chk u_spi_chk (.*);

>>> bench/tb_segment_pair_intersection.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment pair intersection testbench
// Drives pairs of segments into the block, predicts each result with exact
// integer geometry and compares every returned result field by field.
// ----------------------------------------------------------------------------
module tb_segment_pair_intersection;

    typedef spi_pkg::t_coord t_coord;

    localparam int N_RANDOM  = 1200;
    localparam int MAX_CYCLE = 400000;
    localparam int DRAIN     = spi_pkg::LATENCY + 20;

    typedef struct packed {
        logic   hit;
        logic   col;
        t_coord lx;
        t_coord ly;
        t_coord rx;
        t_coord ry;
    } t_answer;

    // One row of the directed table: eight coordinates, and optionally the
    // expected answer when it can be read off directly.
    typedef struct {
        t_coord  p[8];
        bit      typed;
        t_answer ans;
    } t_row;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   start = 1'b0;
    logic   busy;
    t_coord i_a_x = '0, i_a_y = '0, i_b_x = '0, i_b_y = '0;
    t_coord i_c_x = '0, i_c_y = '0, i_d_x = '0, i_d_y = '0;
    logic   o_valid, o_hit, o_collinear;
    t_coord o_left_x, o_left_y, o_right_x, o_right_y;

    t_answer expected_q[$];
    int      n_errors = 0;
    int      n_checked = 0;
    int      n_hits = 0;
    int      n_collinear = 0;
    int      cycle = 0;

    segment_pair_intersection u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_a_x(i_a_x), .i_a_y(i_a_y), .i_b_x(i_b_x), .i_b_y(i_b_y),
        .i_c_x(i_c_x), .i_c_y(i_c_y), .i_d_x(i_d_x), .i_d_y(i_d_y),
        .o_valid(o_valid), .o_hit(o_hit), .o_collinear(o_collinear),
        .o_left_x(o_left_x), .o_left_y(o_left_y),
        .o_right_x(o_right_x), .o_right_y(o_right_y)
    );

    always #5 i_clk = ~i_clk;

    // Watchdog: the slowest correct run is far below this bound.
    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > MAX_CYCLE) begin
            $display("Timeout after %0d cycles", cycle);
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic longint lmin(input longint p, input longint q);
        return (p < q) ? p : q;
    endfunction

    function automatic longint lmax(input longint p, input longint q);
        return (p > q) ? p : q;
    endfunction

    function automatic bit spans_overlap(input longint l1, input longint r1,
                                         input longint l2, input longint r2);
        return lmax(lmin(l1, r1), lmin(l2, r2)) <= lmin(lmax(l1, r1), lmax(l2, r2));
    endfunction

    function automatic bit point_before(input longint px, input longint py,
                                        input longint qx, input longint qy);
        return (px < qx) || ((px == qx) && (py < qy));
    endfunction

    // True when num/den lies in the closed range spanned by e1 and e2 (den > 0).
    function automatic bit ratio_between(input longint e1, input longint e2,
                                         input longint num, input longint den);
        return (lmin(e1, e2) * den <= num) && (num <= lmax(e1, e2) * den);
    endfunction

    // Exact intersection of AB and CD; 64-bit products are exact at 16 bits.
    function automatic t_answer intersect_segments(input t_coord p[8]);
        t_answer r;
        longint ax, ay, bx, by, cx, cy, dx, dy, t;
        longint ma, mb, mc, na, nb, nc, zn, nx, ny;
        r = '0;
        ax = p[0]; ay = p[1]; bx = p[2]; by = p[3];
        cx = p[4]; cy = p[5]; dx = p[6]; dy = p[7];
        if (spans_overlap(ax, bx, cx, dx) && spans_overlap(ay, by, cy, dy)) begin
            ma = ay - by; mb = bx - ax; mc = -ma * ax - mb * ay;
            na = cy - dy; nb = dx - cx; nc = -na * cx - nb * cy;
            zn = ma * nb - mb * na;
            if (zn == 0) begin
                // Parallel: a hit only when each segment lies on the other's line.
                if (ma * cx + mb * cy + mc == 0 && na * ax + nb * ay + nc == 0) begin
                    if (point_before(bx, by, ax, ay)) begin
                        t = ax; ax = bx; bx = t;
                        t = ay; ay = by; by = t;
                    end
                    if (point_before(dx, dy, cx, cy)) begin
                        t = cx; cx = dx; dx = t;
                        t = cy; cy = dy; dy = t;
                    end
                    if (point_before(ax, ay, cx, cy)) begin
                        r.lx = t_coord'(cx); r.ly = t_coord'(cy);
                    end else begin
                        r.lx = t_coord'(ax); r.ly = t_coord'(ay);
                    end
                    if (point_before(dx, dy, bx, by)) begin
                        r.rx = t_coord'(dx); r.ry = t_coord'(dy);
                    end else begin
                        r.rx = t_coord'(bx); r.ry = t_coord'(by);
                    end
                    r.hit = 1'b1;
                    r.col = 1'b1;
                end
            end else begin
                nx = mb * nc - mc * nb;
                ny = mc * na - ma * nc;
                if (zn < 0) begin
                    zn = -zn; nx = -nx; ny = -ny;
                end
                if (ratio_between(ax, bx, nx, zn) && ratio_between(ay, by, ny, zn) &&
                    ratio_between(cx, dx, nx, zn) && ratio_between(cy, dy, ny, zn)) begin
                    // SystemVerilog integer division truncates toward zero.
                    r.lx = t_coord'(nx / zn); r.ly = t_coord'(ny / zn);
                    r.rx = r.lx; r.ry = r.ly;
                    r.hit = 1'b1;
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        n_errors++;
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // Result monitor: every strobe is one transfer that must match the oldest
    // expectation.
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && o_valid) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                want = expected_q.pop_front();
                n_checked++;
                if (want.hit) n_hits++;
                if (want.col) n_collinear++;
                if (o_hit !== want.hit) report_mismatch("hit", o_hit, want.hit);
                if (o_collinear !== want.col)
                    report_mismatch("collinear", o_collinear, want.col);
                if (o_left_x !== want.lx) report_mismatch("left_x", o_left_x, want.lx);
                if (o_left_y !== want.ly) report_mismatch("left_y", o_left_y, want.ly);
                if (o_right_x !== want.rx) report_mismatch("right_x", o_right_x, want.rx);
                if (o_right_y !== want.ry) report_mismatch("right_y", o_right_y, want.ry);
            end
        end
    end

    // Present one pair at the falling edge and hold it until a transfer.
    // The expectation is queued at the accepting rising edge, long before the
    // result can appear.
    task automatic send_pair(input t_coord p[8], input bit typed, input t_answer ans);
        t_answer pred;
        pred = intersect_segments(p);
        if (typed && pred !== ans) begin
            report_mismatch("directed row expectation", longint'(pred.hit),
                            longint'(ans.hit));
        end
        i_a_x <= p[0]; i_a_y <= p[1]; i_b_x <= p[2]; i_b_y <= p[3];
        i_c_x <= p[4]; i_c_y <= p[5]; i_d_x <= p[6]; i_d_y <= p[7];
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        expected_q.insert(expected_q.size(), typed ? ans : pred);
        @(negedge i_clk);
    endtask

    // Each cycle the sender idles with a chance of 31 in 100.
    task automatic idle_sender(input bit allow);
        while (allow && ($urandom_range(99) < 31)) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
    endtask

    // Random coordinate, biased toward small grids so that hits, collinear
    // overlaps and touching endpoints are common.
    function automatic t_coord pick_coord(input int style);
        case (style)
            0: return t_coord'($urandom_range(0, 8) - 4);
            1: return t_coord'(($urandom_range(0, 16) - 8) * 256);
            2: return t_coord'($urandom_range(0, 600) - 300);
            default: return t_coord'($urandom);
        endcase
    endfunction

    t_row    rows[$];
    t_coord  pt[8];
    t_answer no_hit;

    function automatic t_row make_row(input int v0, input int v1, input int v2,
                                      input int v3, input int v4, input int v5,
                                      input int v6, input int v7, input bit typed,
                                      input t_answer ans);
        t_row r;
        r.p[0] = t_coord'(v0); r.p[1] = t_coord'(v1); r.p[2] = t_coord'(v2);
        r.p[3] = t_coord'(v3); r.p[4] = t_coord'(v4); r.p[5] = t_coord'(v5);
        r.p[6] = t_coord'(v6); r.p[7] = t_coord'(v7);
        r.typed = typed;
        r.ans = ans;
        return r;
    endfunction

    initial begin
        int style, k;
        t_answer at_origin, full_col;
        no_hit = '0;
        at_origin = '{hit: 1'b1, col: 1'b0, lx: 0, ly: 0, rx: 0, ry: 0};
        full_col = '{hit: 1'b1, col: 1'b1, lx: -32768, ly: -32768, rx: 32767, ry: 32767};

        // Directed table: boxes apart, parallel, collinear overlap and touch,
        // degenerate points, crossing inside and outside, full-scale extremes.
        rows.insert(rows.size(), make_row(0, 0, 256, 0, 0, 512, 256, 512, 1, no_hit));
        rows.insert(rows.size(), make_row(-256, -256, 256, 256, -256, 256, 256, -256,
                                          1, at_origin));
        rows.insert(rows.size(), make_row(-32768, -32768, 32767, 32767, 32767, 32767,
                                          -32768, -32768, 1, full_col));
        rows.insert(rows.size(), make_row(-32768, -32768, 32767, 32767, -32768, 32767,
                                          32767, -32768, 0, no_hit));
        rows.insert(rows.size(), make_row(0, 0, 0, 0, 0, 0, 0, 0, 0, no_hit));
        rows.insert(rows.size(), make_row(5, 5, 5, 5, 0, 0, 10, 10, 0, no_hit));
        rows.insert(rows.size(), make_row(5, 6, 5, 6, 0, 0, 10, 10, 0, no_hit));
        rows.insert(rows.size(), make_row(0, 0, 10, 0, 5, 0, 20, 0, 0, no_hit));
        rows.insert(rows.size(), make_row(0, 0, 10, 0, 10, 0, 20, 0, 0, no_hit));
        rows.insert(rows.size(), make_row(0, 0, 10, 10, 0, 1, 10, 11, 1, no_hit));
        rows.insert(rows.size(), make_row(0, 0, 0, 10, 0, 3, 0, 7, 0, no_hit));
        rows.insert(rows.size(), make_row(0, 0, 3, 1, 0, 1, 3, 0, 0, no_hit));
        rows.insert(rows.size(), make_row(0, 0, -3, 1, 0, 1, -3, 0, 0, no_hit));
        rows.insert(rows.size(), make_row(0, 0, 4, 4, 4, 0, 3, 1, 0, no_hit));
        rows.insert(rows.size(), make_row(0, 0, 10, 0, 10, 0, 10, 10, 0, no_hit));
        rows.insert(rows.size(), make_row(32767, -32768, -32768, 32767, 0, 0, 1, 1,
                                          0, no_hit));
        rows.insert(rows.size(), make_row(-32768, 0, 32767, 0, 0, -32768, 0, 32767,
                                          0, no_hit));
        rows.insert(rows.size(), make_row(-1, -1, -1, -1, -1, -1, -1, -1, 0, no_hit));

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (rows[r]) send_pair(rows[r].p, rows[r].typed, rows[r].ans);

        for (int n = 0; n < N_RANDOM; n++) begin
            // The middle stretch runs back to back with no sender gaps.
            idle_sender(n < 400 || n >= 700);
            style = $urandom_range(0, 4);
            for (int j = 0; j < 8; j++) pt[j] = pick_coord(style == 4 ? 3 : style);
            k = $urandom_range(0, 9);
            // Some pairs are built collinear by placing C and D on AB's line.
            if (k < 2 && style < 3) begin
                pt[4] = pt[0] + (pt[2] - pt[0]) * t_coord'(k);
                pt[5] = pt[1] + (pt[3] - pt[1]) * t_coord'(k);
                pt[6] = pt[0] - (pt[2] - pt[0]);
                pt[7] = pt[1] - (pt[3] - pt[1]);
            end
            send_pair(pt, 1'b0, no_hit);
            // Once, hold off until the pipeline has emptied.
            if (n == 600) begin
                start <= 1'b0;
                while (expected_q.size() != 0) @(negedge i_clk);
            end
        end
        start <= 1'b0;

        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN) @(negedge i_clk);

        $display("Checked %0d results: %0d hits, %0d collinear overlaps.",
                 n_checked, n_hits, n_collinear);
        if (n_errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

>>> segment_pair_intersection.f
+incdir+hdl
hdl/spi_pkg.sv
hdl/spi_geom.sv
hdl/spi_div.sv
hdl/segment_pair_intersection.sv
hdl/spi_chk.sv
bench/tb_segment_pair_intersection.sv
